// ===== src/sfs_pkg.sv =====
// Shared constants and opcodes of the segment fit search block.
// No dependencies; sfs_if and segment_fit_search take names from here by scope.
`timescale 1ns / 1ps

package sfs_pkg;

   localparam int SEGMENTS_DEF      = 64;
   localparam int CAPACITY_BITS_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int FIELD_W  = 16;
   localparam int OUT_IDX_W = 6;

   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

endpackage

// ===== src/sfs_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on sfs_pkg for field widths.
`timescale 1ns / 1ps

interface sfs_req_if;
   logic                           valid;
   logic                           ready;
   logic [sfs_pkg::OPCODE_W-1:0]   opcode;
   logic [sfs_pkg::FIELD_W-1:0]    segment_capacity_in;
   logic                           segment_is_free;
   logic [sfs_pkg::FIELD_W-1:0]    request_size;

   modport source (output valid, opcode, segment_capacity_in, segment_is_free, request_size,
                   input ready);
   modport sink   (input valid, opcode, segment_capacity_in, segment_is_free, request_size,
                   output ready);
endinterface

interface sfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           first_found;
   logic [sfs_pkg::OUT_IDX_W-1:0]  first_index;
   logic [sfs_pkg::FIELD_W-1:0]    first_capacity;
   logic                           best_found;
   logic [sfs_pkg::OUT_IDX_W-1:0]  best_index;
   logic [sfs_pkg::FIELD_W-1:0]    best_capacity;
   logic                           worst_found;
   logic [sfs_pkg::OUT_IDX_W-1:0]  worst_index;
   logic [sfs_pkg::FIELD_W-1:0]    worst_capacity;

   modport source (output valid, first_found, first_index, first_capacity,
                   best_found, best_index, best_capacity,
                   worst_found, worst_index, worst_capacity,
                   input ready);
   modport sink   (input valid, first_found, first_index, first_capacity,
                   best_found, best_index, best_capacity,
                   worst_found, worst_index, worst_capacity,
                   output ready);
endinterface

// ===== src/sfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfs_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== src/segment_fit_search.sv =====
// Segment table with first, best and worst fit search over free segments.
// Depends on sfs_pkg, sfs_if (sfs_req_if, sfs_rsp_if) and sfs_ram.
//
//   channel    dir   transfer carries
//   req_chan   in    opcode, segment capacity, free mark, request size
//   rsp_chan   out   found/index/capacity for first, best and worst fit
//
// Clear, append and unused opcodes give no response.
// A query reads the stored segments from the RAM one per cycle through one
// compare/subtract unit.
// Reset empties the table at once; no clearing pass.
// A finished response waits in the output register; a new request is taken
// meanwhile, but a later query holds in its last state until the register frees.
`timescale 1ns / 1ps

module segment_fit_search #(
   parameter int SEGMENTS      = sfs_pkg::SEGMENTS_DEF,
   parameter int CAPACITY_BITS = sfs_pkg::CAPACITY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sfs_req_if.sink      req_chan,
   sfs_rsp_if.source    rsp_chan
);

   localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int CNT_W = $clog2(SEGMENTS + 1);
   localparam int CMP_W = (CAPACITY_BITS > sfs_pkg::FIELD_W) ? CAPACITY_BITS : sfs_pkg::FIELD_W;
   localparam int FW    = sfs_pkg::FIELD_W;
   localparam int OW    = sfs_pkg::OUT_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } sfs_state_type;

   sfs_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             issue_ff, issue_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [FW-1:0]    request_ff, request_in;

   logic                     first_found_ff, first_found_in;
   logic [IDX_W-1:0]         first_idx_ff, first_idx_in;
   logic [CAPACITY_BITS-1:0] first_cap_ff, first_cap_in;
   logic                     best_found_ff, best_found_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [CAPACITY_BITS-1:0] best_cap_ff, best_cap_in;
   logic [CMP_W-1:0]         best_slack_ff, best_slack_in;
   logic                     worst_found_ff, worst_found_in;
   logic [IDX_W-1:0]         worst_idx_ff, worst_idx_in;
   logic [CAPACITY_BITS-1:0] worst_cap_ff, worst_cap_in;
   logic [CMP_W-1:0]         worst_slack_ff, worst_slack_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ff_found_ff [3];
   logic [OW-1:0] rsp_ff_idx_ff [3];
   logic [FW-1:0] rsp_ff_cap_ff [3];
   logic          rsp_load;

   logic                     ram_wr_en;
   logic [CAPACITY_BITS:0]   ram_wr_data;
   logic                     ram_rd_en;
   logic [CAPACITY_BITS:0]   ram_rd_data;

   logic [CAPACITY_BITS+FW-1:0] cap_in_ext;
   logic [CMP_W+FW-1:0]         rd_cap_ext;
   logic [CMP_W+FW-1:0]         req_ext;
   logic [CMP_W-1:0]            rd_cap_w;
   logic [CMP_W-1:0]            req_w;
   logic [CMP_W-1:0]            slack;
   logic                        fits;
   logic                        req_xfer;

   // mask the appended capacity to the table width
   assign cap_in_ext  = {{CAPACITY_BITS{1'b0}}, req_chan.segment_capacity_in};
   assign ram_wr_data = {req_chan.segment_is_free, cap_in_ext[CAPACITY_BITS-1:0]};

   assign rd_cap_ext = {{(CMP_W + FW - CAPACITY_BITS){1'b0}}, ram_rd_data[CAPACITY_BITS-1:0]};
   assign req_ext    = {{CMP_W{1'b0}}, request_ff};
   assign rd_cap_w   = rd_cap_ext[CMP_W-1:0];
   assign req_w      = req_ext[CMP_W-1:0];
   assign slack      = rd_cap_w - req_w;
   assign fits       = ram_rd_data[CAPACITY_BITS] && (rd_cap_w >= req_w);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign ram_wr_en      = req_xfer && (req_chan.opcode == sfs_pkg::OP_APPEND)
                           && (count_ff < CNT_W'(SEGMENTS));
   assign ram_rd_en      = (state_ff == ST_SCAN) && issue_ff;
   assign rsp_load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   sfs_ram #(
      .WIDTH (CAPACITY_BITS + 1),
      .DEPTH (SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      addr_in        = addr_ff;
      cmp_vld_in     = 1'b0;
      cmp_last_in    = 1'b0;
      cmp_idx_in     = addr_ff;
      request_in     = request_ff;
      first_found_in = first_found_ff;
      first_idx_in   = first_idx_ff;
      first_cap_in   = first_cap_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_cap_in    = best_cap_ff;
      best_slack_in  = best_slack_ff;
      worst_found_in = worst_found_ff;
      worst_idx_in   = worst_idx_ff;
      worst_cap_in   = worst_cap_ff;
      worst_slack_in = worst_slack_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_chan.opcode)
                  sfs_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  sfs_pkg::OP_APPEND: begin
                     if (ram_wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  sfs_pkg::OP_QUERY: begin
                     request_in     = req_chan.request_size;
                     first_found_in = 1'b0;
                     first_idx_in   = '0;
                     first_cap_in   = '0;
                     best_found_in  = 1'b0;
                     best_idx_in    = '0;
                     best_cap_in    = '0;
                     best_slack_in  = '0;
                     worst_found_in = 1'b0;
                     worst_idx_in   = '0;
                     worst_cap_in   = '0;
                     worst_slack_in = '0;
                     addr_in        = '0;
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  sfs_pkg::OP_UNUSED: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one read per cycle
            if (issue_ff) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = addr_ff;
               cmp_last_in = (CNT_W'(addr_ff) + CNT_W'(1) == count_ff);
               addr_in     = addr_ff + IDX_W'(1);
               if (cmp_last_in) begin
                  issue_in = 1'b0;
               end
            end
            // evaluate the entry read last cycle
            if (cmp_vld_ff) begin
               if (fits) begin
                  if (!first_found_ff) begin
                     first_found_in = 1'b1;
                     first_idx_in   = cmp_idx_ff;
                     first_cap_in   = ram_rd_data[CAPACITY_BITS-1:0];
                  end
                  if (!best_found_ff || (slack < best_slack_ff)) begin
                     best_found_in = 1'b1;
                     best_idx_in   = cmp_idx_ff;
                     best_cap_in   = ram_rd_data[CAPACITY_BITS-1:0];
                     best_slack_in = slack;
                  end
                  if (!worst_found_ff || (slack > worst_slack_ff)) begin
                     worst_found_in = 1'b1;
                     worst_idx_in   = cmp_idx_ff;
                     worst_cap_in   = ram_rd_data[CAPACITY_BITS-1:0];
                     worst_slack_in = slack;
                  end
               end
               if (cmp_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      cmp_last_ff    <= cmp_last_in;
      cmp_idx_ff     <= cmp_idx_in;
      request_ff     <= request_in;
      first_found_ff <= first_found_in;
      first_idx_ff   <= first_idx_in;
      first_cap_ff   <= first_cap_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_cap_ff    <= best_cap_in;
      best_slack_ff  <= best_slack_in;
      worst_found_ff <= worst_found_in;
      worst_idx_ff   <= worst_idx_in;
      worst_cap_ff   <= worst_cap_in;
      worst_slack_ff <= worst_slack_in;
   end

   // trim index and capacity to the response field widths
   logic [IDX_W+OW-1:0]         first_idx_ext, best_idx_ext, worst_idx_ext;
   logic [CAPACITY_BITS+FW-1:0] first_cap_ext, best_cap_ext, worst_cap_ext;

   assign first_idx_ext = {{OW{1'b0}}, first_idx_ff};
   assign best_idx_ext  = {{OW{1'b0}}, best_idx_ff};
   assign worst_idx_ext = {{OW{1'b0}}, worst_idx_ff};
   assign first_cap_ext = {{FW{1'b0}}, first_cap_ff};
   assign best_cap_ext  = {{FW{1'b0}}, best_cap_ff};
   assign worst_cap_ext = {{FW{1'b0}}, worst_cap_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff_found_ff[0] <= first_found_ff;
         rsp_ff_idx_ff[0]   <= first_idx_ext[OW-1:0];
         rsp_ff_cap_ff[0]   <= first_cap_ext[FW-1:0];
         rsp_ff_found_ff[1] <= best_found_ff;
         rsp_ff_idx_ff[1]   <= best_idx_ext[OW-1:0];
         rsp_ff_cap_ff[1]   <= best_cap_ext[FW-1:0];
         rsp_ff_found_ff[2] <= worst_found_ff;
         rsp_ff_idx_ff[2]   <= worst_idx_ext[OW-1:0];
         rsp_ff_cap_ff[2]   <= worst_cap_ext[FW-1:0];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.first_found    = rsp_ff_found_ff[0];
   assign rsp_chan.first_index    = rsp_ff_idx_ff[0];
   assign rsp_chan.first_capacity = rsp_ff_cap_ff[0];
   assign rsp_chan.best_found     = rsp_ff_found_ff[1];
   assign rsp_chan.best_index     = rsp_ff_idx_ff[1];
   assign rsp_chan.best_capacity  = rsp_ff_cap_ff[1];
   assign rsp_chan.worst_found    = rsp_ff_found_ff[2];
   assign rsp_chan.worst_index    = rsp_ff_idx_ff[2];
   assign rsp_chan.worst_capacity = rsp_ff_cap_ff[2];

endmodule
